/* rtl/mot_pkg.sv */
// Shared types and codes of the multi-slot one-shot timer.
package mot_pkg;

    // Command codes carried in s_tuser
    localparam logic [2:0] ACT_START   = 3'd0;
    localparam logic [2:0] ACT_STOP    = 3'd1;
    localparam logic [2:0] ACT_RESTART = 3'd2;
    localparam logic [2:0] ACT_QUERY   = 3'd3;
    localparam logic [2:0] ACT_TICK    = 3'd4;
    localparam logic [2:0] ACT_SERVICE = 3'd5;

    localparam int SLOT_W = 5;
    localparam int TIMEOUT_W = 32;
    localparam int MASK_W = 32;

    // Per-cell control, slot decode already folded in
    typedef struct packed {
        logic clear;      // free the slot
        logic load_free;  // arm the slot if it is free
        logic load_any;   // arm the slot regardless (restart)
        logic tick;       // count down if running
        logic serve;      // free the slot if it holds the grant
    } cell_ctrl_t;

endpackage

/* rtl/mot_cell.sv */
// One timer slot: present and pending flags, countdown, and a link of the service grant chain.
module mot_cell #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mot_pkg::cell_ctrl_t    ctrl,
    input  logic [COUNT_WIDTH-1:0] load_value,
    input  logic                   grant_in,
    output logic                   grant_out,
    output logic                   fire,
    output logic                   present,
    output logic                   pending,
    output logic                   present_next,
    output logic                   pending_next
);

    logic                   present_reg;
    logic                   pending_reg;
    logic [COUNT_WIDTH-1:0] remaining_reg;
    logic [COUNT_WIDTH-1:0] remaining_next;

    // lowest pending slot takes the grant, the rest is passed up the row
    assign fire      = grant_in & pending_reg;
    assign grant_out = grant_in & ~pending_reg;
    assign present   = present_reg;
    assign pending   = pending_reg;

    always_comb
    begin
        present_next   = present_reg;
        pending_next   = pending_reg;
        remaining_next = remaining_reg;
        if (ctrl.clear)
        begin
            present_next = 1'b0;
            pending_next = 1'b0;
        end
        if (ctrl.load_any || (ctrl.load_free && !present_reg))
        begin
            present_next   = 1'b1;
            pending_next   = 1'b0;
            remaining_next = load_value;
        end
        if (ctrl.tick && present_reg && !pending_reg)
        begin
            if (remaining_reg != '0)
            begin
                remaining_next = remaining_reg - COUNT_WIDTH'(1);
            end
            if (remaining_reg <= COUNT_WIDTH'(1))
            begin
                pending_next = 1'b1;
            end
        end
        if (ctrl.serve && fire)
        begin
            present_next = 1'b0;
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            present_reg <= present_next;
            pending_reg <= pending_next;
        end
    end

    // count is only read while the slot is present
    always_ff @(posedge clk)
    begin
        remaining_reg <= remaining_next;
    end

    // an expired slot is always still held
    a_pend_pres: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> present_reg)
        else $error("pending slot not present");

    // a tick never arms a slot that was free
    a_tick_arm: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.tick && !present_reg) |=> !present_reg)
        else $error("tick armed a free slot");

    // a granted slot is freed by a service step
    a_serve_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.serve && fire) |=> (!present_reg && !pending_reg))
        else $error("served slot not freed");

endmodule

/* rtl/multi_slot_oneshot_timer_unit.sv */
// Top level of the multi-slot one-shot timer: command decode, cell row and result register.
//
// Holds NUM_SLOTS one-shot timers as a row of identical cells, one per slot,
// each keeping its present and pending flags and a COUNT_WIDTH-bit countdown.
// Commands arrive on the s_ side (command code in s_tuser) and results leave
// through a single output register on the m_ side, so a new command is taken
// while the previous result is being drained. Start, stop, restart, query and
// tick each give one result, registered at the transfer; with the sink always
// ready and no service under way a command is taken every cycle. Tick counts
// every running cell down in parallel, saturating at zero. Service with nothing
// pending gives one result with fired_valid clear. Otherwise the block first
// enters the service sequence, loading no result, and then emits one pending
// slot per cycle while the sink is ready, lowest index first, chosen by a grant
// chain that ripples along the cell row; no command is taken until the final
// result (tlast high) is loaded. pending_mask always shows the pending flags of
// slots 0 to 31 after the transfer's effect. Slot indices at or above NUM_SLOTS
// are treated as absent.
module multi_slot_oneshot_timer_unit #(
    parameter int NUM_SLOTS   = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // slot_index[4:0], timeout_value[36:5], zero pad
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[0], is_present[1], fired_valid[2],
                                   // fired_slot[7:3], pending_mask[39:8]
    output logic        m_tlast    // last
);

    localparam int TW = (COUNT_WIDTH < mot_pkg::TIMEOUT_W) ? COUNT_WIDTH : mot_pkg::TIMEOUT_W;
    localparam int MW = (NUM_SLOTS < mot_pkg::MASK_W) ? NUM_SLOTS : mot_pkg::MASK_W;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SERVE = 1'b1;

    logic state_reg;
    logic state_next;

    // input fields
    logic [2:0]                   action;
    logic [mot_pkg::SLOT_W-1:0]   slot_index;
    logic [TW-1:0]                timeout_low;
    logic [COUNT_WIDTH-1:0]       load_value;
    logic                         t_nz;

    assign action      = s_tuser;
    assign slot_index  = s_tdata[4:0];
    assign timeout_low = s_tdata[5 +: TW];
    assign load_value  = COUNT_WIDTH'(timeout_low);
    assign t_nz        = |timeout_low;

    // output register
    logic                         out_valid_reg;
    logic                         status_reg;
    logic                         is_present_reg;
    logic                         fired_valid_reg;
    logic [mot_pkg::SLOT_W-1:0]   fired_slot_reg;
    logic                         last_reg;
    logic [mot_pkg::MASK_W-1:0]   pending_mask_reg;

    logic out_free;
    logic accept;
    logic serve_step;

    // cell row signals
    mot_pkg::cell_ctrl_t ctrl [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] hit;
    logic [NUM_SLOTS-1:0] present_q;
    logic [NUM_SLOTS-1:0] pending_q;
    logic [NUM_SLOTS-1:0] present_d;
    logic [NUM_SLOTS-1:0] pending_d;
    logic [NUM_SLOTS-1:0] fire;
    logic [NUM_SLOTS:0]   grant;

    logic slot_ok;
    logic any_pend;
    logic is_start;
    logic is_stop;
    logic is_restart;
    logic is_tick;
    logic is_service;
    logic cmd_status;
    logic cmd_present;
    logic [mot_pkg::SLOT_W-1:0] fired_idx;
    logic fired_last;
    logic [mot_pkg::MASK_W-1:0] mask_after;

    assign out_free   = !out_valid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE) && out_free;
    assign accept     = s_tvalid && s_tready;
    assign serve_step = (state_reg == ST_SERVE) && out_free;

    // slot decode; indices beyond the row match nothing
    always_comb
    begin
        hit = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            hit[i] = (int'(slot_index) == i);
        end
    end
    assign slot_ok  = |hit;
    assign any_pend = |pending_q;

    always_comb
    begin
        is_start   = 1'b0;
        is_stop    = 1'b0;
        is_restart = 1'b0;
        is_tick    = 1'b0;
        is_service = 1'b0;
        unique case (action)
            mot_pkg::ACT_START:   is_start   = 1'b1;
            mot_pkg::ACT_STOP:    is_stop    = 1'b1;
            mot_pkg::ACT_RESTART: is_restart = 1'b1;
            mot_pkg::ACT_QUERY:   ;
            mot_pkg::ACT_TICK:    is_tick    = 1'b1;
            mot_pkg::ACT_SERVICE: is_service = 1'b1;
            default:              ;
        endcase
    end

    // per-cell control
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            ctrl[i].clear     = accept && hit[i] && (is_stop || is_restart);
            ctrl[i].load_free = accept && hit[i] && is_start && t_nz;
            ctrl[i].load_any  = accept && hit[i] && is_restart && t_nz;
            ctrl[i].tick      = accept && is_tick;
            ctrl[i].serve     = serve_step;
        end
    end

    assign grant[0] = 1'b1;

    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_cell
        mot_cell #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl[g]),
            .load_value   (load_value),
            .grant_in     (grant[g]),
            .grant_out    (grant[g+1]),
            .fire         (fire[g]),
            .present      (present_q[g]),
            .pending      (pending_q[g]),
            .present_next (present_d[g]),
            .pending_next (pending_d[g])
        );
    end

    // pending flags of the low slots after this cycle's effect
    assign mask_after = mot_pkg::MASK_W'(pending_d[MW-1:0]);

    // command result
    always_comb
    begin
        cmd_status  = 1'b0;
        cmd_present = 1'b0;
        unique case (action) inside
            mot_pkg::ACT_START,
            mot_pkg::ACT_RESTART:
            begin
                cmd_status  = !slot_ok || !t_nz;
                cmd_present = |(present_d & hit);
            end
            mot_pkg::ACT_STOP:
            begin
                cmd_status  = !slot_ok || !(|(present_q & hit));
                cmd_present = |(present_d & hit);
            end
            mot_pkg::ACT_QUERY:
            begin
                cmd_present = |(present_q & hit);
            end
            mot_pkg::ACT_TICK,
            mot_pkg::ACT_SERVICE: ;
            default:
            begin
                cmd_status = 1'b1;
            end
        endcase
    end

    // slot holding the grant and whether it is the final one
    always_comb
    begin
        fired_idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (fire[i])
            begin
                fired_idx = fired_idx | mot_pkg::SLOT_W'(i);
            end
        end
    end
    assign fired_last = !(|(pending_q & ~fire));

    always_comb
    begin
        state_next = state_reg;
        if (accept && is_service && any_pend)
        begin
            state_next = ST_SERVE;
        end
        else if (serve_step && fired_last)
        begin
            state_next = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (serve_step || (accept && !(is_service && any_pend)))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (serve_step)
        begin
            status_reg       <= 1'b0;
            is_present_reg   <= 1'b0;
            fired_valid_reg  <= 1'b1;
            fired_slot_reg   <= fired_idx;
            last_reg         <= fired_last;
            pending_mask_reg <= mask_after;
        end
        else if (accept)
        begin
            status_reg       <= cmd_status;
            is_present_reg   <= cmd_present;
            fired_valid_reg  <= 1'b0;
            fired_slot_reg   <= '0;
            last_reg         <= 1'b1;
            pending_mask_reg <= mask_after;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {pending_mask_reg, fired_slot_reg, fired_valid_reg,
                       is_present_reg, status_reg};

    // at most one slot holds the service grant
    a_one_fire: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(fire))
        else $error("more than one slot granted");

    // the service sequence only runs while something is pending
    a_serve_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SERVE) |-> any_pend)
        else $error("service sequence with nothing pending");

    // commands are held off during the service sequence
    a_serve_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SERVE) |-> !s_tready)
        else $error("command taken during service");

    // leaving the service sequence loads a final result
    a_serve_last: assert property (@(posedge clk) disable iff (!rst_n)
        (serve_step && fired_last) |=> (out_valid_reg && last_reg && fired_valid_reg))
        else $error("service ended without final result");

endmodule

/* test/mot_timer_checker.sv */
// Checker for the multi-slot one-shot timer: watches both streams, predicts results and compares.
module mot_timer_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 32;

    typedef struct packed {
        logic                       status;
        logic                       is_present;
        logic                       fired_valid;
        logic [mot_pkg::SLOT_W-1:0] fired_slot;
        logic                       last;
        logic [mot_pkg::MASK_W-1:0] pending_mask;
    } timer_result_t;

    // Shadow of the slot row
    logic                          armed [SLOTS];
    logic                          expired [SLOTS];
    logic [mot_pkg::TIMEOUT_W-1:0] ticks_left [SLOTS];

    timer_result_t expected_results [$];

    function automatic logic [mot_pkg::MASK_W-1:0] expired_mask();
        logic [mot_pkg::MASK_W-1:0] m;
        m = '0;
        for (int i = 0; i < SLOTS; i++)
            m[i] = expired[i];
        return m;
    endfunction

    function automatic void push_result(logic st, logic pres, logic fv,
                                        logic [mot_pkg::SLOT_W-1:0] fs, logic lst);
        timer_result_t r;
        r.status       = st;
        r.is_present   = pres;
        r.fired_valid  = fv;
        r.fired_slot   = fs;
        r.last         = lst;
        r.pending_mask = expired_mask();
        expected_results.push_back(r);
    endfunction

    // Arms a free slot; a present slot is left alone, a zero timeout is refused
    function automatic logic arm_slot(logic [mot_pkg::SLOT_W-1:0] s,
                                      logic [mot_pkg::TIMEOUT_W-1:0] t);
        if (t == '0)
            return 1'b1;
        if (!armed[s])
        begin
            armed[s]      = 1'b1;
            expired[s]    = 1'b0;
            ticks_left[s] = t;
        end
        return 1'b0;
    endfunction

    function automatic void predict_command(logic [2:0] act,
                                            logic [mot_pkg::SLOT_W-1:0] s,
                                            logic [mot_pkg::TIMEOUT_W-1:0] t);
        logic st;
        int   fired;
        st    = 1'b0;
        fired = 0;
        case (act)
            mot_pkg::ACT_START:
            begin
                st = arm_slot(s, t);
                push_result(st, armed[s], 1'b0, '0, 1'b1);
            end
            mot_pkg::ACT_STOP:
            begin
                if (!armed[s])
                    st = 1'b1;
                armed[s]   = 1'b0;
                expired[s] = 1'b0;
                push_result(st, armed[s], 1'b0, '0, 1'b1);
            end
            mot_pkg::ACT_RESTART:
            begin
                armed[s]   = 1'b0;
                expired[s] = 1'b0;
                st = arm_slot(s, t);
                push_result(st, armed[s], 1'b0, '0, 1'b1);
            end
            mot_pkg::ACT_QUERY:
                push_result(1'b0, armed[s], 1'b0, '0, 1'b1);
            mot_pkg::ACT_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (armed[i] && !expired[i])
                    begin
                        if (ticks_left[i] != '0)
                            ticks_left[i] = ticks_left[i] - 1'b1;
                        if (ticks_left[i] == '0)
                            expired[i] = 1'b1;
                    end
                end
                push_result(1'b0, 1'b0, 1'b0, '0, 1'b1);
            end
            mot_pkg::ACT_SERVICE:
            begin
                // lowest index first; each slot freed before its result is formed
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (expired[i])
                    begin
                        expired[i] = 1'b0;
                        armed[i]   = 1'b0;
                        push_result(1'b0, 1'b0, 1'b1, mot_pkg::SLOT_W'(i), 1'b0);
                        fired++;
                    end
                end
                if (fired == 0)
                    push_result(1'b0, 1'b0, 1'b0, '0, 1'b1);
                else
                    expected_results[expected_results.size() - 1].last = 1'b1;
            end
            default:
                push_result(1'b1, 1'b0, 1'b0, '0, 1'b1);
        endcase
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                armed[i]      = 1'b0;
                expired[i]    = 1'b0;
                ticks_left[i] = '0;
            end
            expected_results.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_command(s_tuser, s_tdata[4:0], s_tdata[36:5]);
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", m_tdata[31:0], '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[0] !== want.status)
                        report_mismatch("status", 32'(m_tdata[0]), 32'(want.status));
                    if (m_tdata[1] !== want.is_present)
                        report_mismatch("is_present", 32'(m_tdata[1]),
                                        32'(want.is_present));
                    if (m_tdata[2] !== want.fired_valid)
                        report_mismatch("fired_valid", 32'(m_tdata[2]),
                                        32'(want.fired_valid));
                    if (m_tdata[7:3] !== want.fired_slot)
                        report_mismatch("fired_slot", 32'(m_tdata[7:3]),
                                        32'(want.fired_slot));
                    if (m_tlast !== want.last)
                        report_mismatch("last", 32'(m_tlast), 32'(want.last));
                    if (m_tdata[39:8] !== want.pending_mask)
                        report_mismatch("pending_mask", m_tdata[39:8], want.pending_mask);
                end
            end
        end
        results_due = expected_results.size();
    end

endmodule

/* test/tb_multi_slot_oneshot_timer_unit.sv */
// Testbench top for the multi-slot one-shot timer: stimulus, flow control and verdict.
module tb_multi_slot_oneshot_timer_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 380;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // slot_index[4:0], timeout_value[36:5], zero pad
    logic [2:0]  s_tuser  = '0;   // action[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // status[0], is_present[1], fired_valid[2],
                                  // fired_slot[7:3], pending_mask[39:8]
    logic        m_tlast;

    int mismatch_count;
    int results_due;
    int cmd_count = 0;
    // Windows where neither side idles
    bit calm      = 1'b0;

    multi_slot_oneshot_timer_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    mot_timer_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly short gaps, the odd long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Timeouts kept short on the whole so that slots actually expire
    function automatic logic [31:0] pick_timeout();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 68)
            return $urandom_range(1, 6);
        if (r < 85)
            return $urandom_range(7, 60);
        return $urandom;
    endfunction

    function automatic logic [4:0] pick_slot();
        return 5'($urandom_range(0, 31));
    endfunction

    // Entered and left at a falling edge; holds tvalid until the transfer
    task automatic send_cmd(logic [2:0] act, logic [4:0] slot, logic [31:0] tmo);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {3'b000, tmo, slot};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        cmd_count++;
        calm = ((cmd_count / 64) % 4) == 2;
    endtask

    // Arm a batch with short timeouts, let them run out, then drain them
    task automatic run_burst();
        int n;
        n = $urandom_range(2, 12);
        if ($urandom_range(0, 9) == 0)
        begin
            for (int s = 0; s < 32; s++)
                send_cmd(mot_pkg::ACT_START, 5'(s), $urandom_range(1, 2));
        end
        else
        begin
            repeat (n)
                send_cmd(mot_pkg::ACT_START, pick_slot(), $urandom_range(1, 2));
        end
        send_cmd(mot_pkg::ACT_TICK, pick_slot(), $urandom);
        send_cmd(mot_pkg::ACT_TICK, pick_slot(), $urandom);
        if ($urandom_range(0, 1))
            send_cmd(mot_pkg::ACT_QUERY, pick_slot(), $urandom);
        send_cmd(mot_pkg::ACT_SERVICE, pick_slot(), $urandom);
    endtask

    task automatic send_random_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 22)
            send_cmd(mot_pkg::ACT_START, pick_slot(), pick_timeout());
        else if (r < 34)
            send_cmd(mot_pkg::ACT_STOP, pick_slot(), $urandom);
        else if (r < 46)
            send_cmd(mot_pkg::ACT_RESTART, pick_slot(), pick_timeout());
        else if (r < 56)
            send_cmd(mot_pkg::ACT_QUERY, pick_slot(), $urandom);
        else if (r < 80)
            send_cmd(mot_pkg::ACT_TICK, pick_slot(), $urandom);
        else if (r < 95)
            send_cmd(mot_pkg::ACT_SERVICE, pick_slot(), $urandom);
        else
            send_cmd(3'($urandom_range(6, 7)), pick_slot(), $urandom);
    endtask

    // Sink side: random stall runs, ready throughout the calm windows
    initial
    begin
        int  hold;
        bit  ready_now;
        int  r;
        hold      = 0;
        ready_now = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    ready_now = 1'b1;
                    hold      = $urandom_range(1, 20);
                end
                else if (r < 90)
                begin
                    ready_now = 1'b0;
                    hold      = $urandom_range(1, 3);
                end
                else
                begin
                    ready_now = 1'b0;
                    hold      = $urandom_range(5, 30);
                end
            end
            hold--;
            m_tready <= calm ? 1'b1 : ready_now;
        end
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #12_000_000;
        $display("tb_multi_slot_oneshot_timer_unit NOT OK");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: error paths, field extremes, every command
        send_cmd(mot_pkg::ACT_QUERY,   5'd0,  32'd0);          // absent slot
        send_cmd(mot_pkg::ACT_START,   5'd0,  32'd0);          // zero timeout refused
        send_cmd(mot_pkg::ACT_START,   5'd0,  32'd1);
        send_cmd(mot_pkg::ACT_START,   5'd31, 32'hFFFF_FFFF);
        send_cmd(mot_pkg::ACT_START,   5'd0,  32'd5);          // already armed, left alone
        send_cmd(mot_pkg::ACT_QUERY,   5'd31, 32'd0);
        send_cmd(mot_pkg::ACT_STOP,    5'd7,  32'd0);          // stop on absent slot
        send_cmd(mot_pkg::ACT_START,   5'd7,  32'd2);
        send_cmd(mot_pkg::ACT_TICK,    5'd0,  32'd0);          // slot 0 expires
        send_cmd(mot_pkg::ACT_SERVICE, 5'd0,  32'd0);
        send_cmd(mot_pkg::ACT_SERVICE, 5'd0,  32'd0);          // nothing pending
        send_cmd(mot_pkg::ACT_TICK,    5'd0,  32'd0);          // slot 7 expires
        send_cmd(mot_pkg::ACT_STOP,    5'd7,  32'd0);          // stop while pending
        send_cmd(mot_pkg::ACT_QUERY,   5'd7,  32'd0);
        send_cmd(mot_pkg::ACT_RESTART, 5'd31, 32'd0);          // freed, then refused
        send_cmd(mot_pkg::ACT_RESTART, 5'd31, 32'd1);
        send_cmd(mot_pkg::ACT_RESTART, 5'd31, 32'd3);          // re-armed over a running slot
        send_cmd(mot_pkg::ACT_START,   5'd16, 32'd1);
        send_cmd(mot_pkg::ACT_START,   5'd1,  32'd1);
        send_cmd(mot_pkg::ACT_TICK,    5'd0,  32'd0);          // slots 1 and 16 expire together
        send_cmd(3'd6,                 5'd0,  32'd0);          // undefined commands
        send_cmd(3'd7,                 5'd31, 32'hAAAA_AAAA);
        send_cmd(mot_pkg::ACT_SERVICE, 5'd0,  32'd0);          // two results, lowest first
        send_cmd(mot_pkg::ACT_TICK,    5'd0,  32'd0);
        send_cmd(mot_pkg::ACT_TICK,    5'd0,  32'd0);
        send_cmd(mot_pkg::ACT_SERVICE, 5'd0,  32'd0);

        cmd_count = 0;
        while (cmd_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 15)
                run_burst();
            else
                send_random_cmd();
        end
        s_tvalid <= 1'b0;

        while (results_due != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_multi_slot_oneshot_timer_unit OK");
        else
            $display("tb_multi_slot_oneshot_timer_unit NOT OK");
        $finish;
    end

endmodule
